>>> design/irp_pkg.sv
// Shared types, constants and helpers of the iRPROP- weight update engine.
package irp_pkg;

    localparam int NUM_WEIGHTS = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

    localparam int IDX_W       = 12;
    localparam int WORD_W      = 32;
    localparam int STEP_W      = 31;
    localparam int SIGN_W      = 2;
    localparam int MODE_W      = 2;
    localparam int GROW_W      = 19;
    localparam int SHRINK_W    = 17;
    localparam int DECAY_W     = 17;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam int IN_BITS     = IDX_W + 2 * WORD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = IDX_W + WORD_W + STEP_W + SIGN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [SIGN_W-1:0]    sgn_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_UPDATE = 2'd0;
    localparam mode_t MODE_LOAD   = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;

    localparam sgn_t SGN_ZERO = 2'd0;
    localparam sgn_t SGN_POS  = 2'd1;
    localparam sgn_t SGN_NEG  = 2'd2;

    localparam cfg_idx_t CFG_GROW      = 3'd0;
    localparam cfg_idx_t CFG_SHRINK    = 3'd1;
    localparam cfg_idx_t CFG_STEP_MAX  = 3'd2;
    localparam cfg_idx_t CFG_STEP_MIN  = 3'd3;
    localparam cfg_idx_t CFG_STEP_INIT = 3'd4;
    localparam cfg_idx_t CFG_DECAY     = 3'd5;

    typedef struct packed {
        logic [GROW_W-1:0]      grow_factor;
        logic [SHRINK_W-1:0]    shrink_factor;
        logic [STEP_W-1:0]      step_max;
        logic [STEP_W-1:0]      step_min;
        logic [STEP_W-1:0]      step_init;
        logic [DECAY_W-1:0]     decay;
    } cfg_t;

    typedef struct packed {
        sgn_t               sign;
        logic [STEP_W-1:0]  step;
        logic [WORD_W-1:0]  weight;
    } entry_t;

    function automatic logic is_writer(input mode_t mode);
        return (mode == MODE_UPDATE) || (mode == MODE_LOAD);
    endfunction

endpackage

>>> design/irp_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module irp_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/irp_cfg.sv
// Configuration register bank of the iRPROP- weight update engine.
module irp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output irp_pkg::cfg_t                   cfg
);
    import irp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grow_factor   <= GROW_W'(78643);
            cfg_reg.shrink_factor <= SHRINK_W'(32768);
            cfg_reg.step_max      <= STEP_W'(3276800);
            cfg_reg.step_min      <= STEP_W'(1);
            cfg_reg.step_init     <= STEP_W'(6554);
            cfg_reg.decay         <= DECAY_W'(0);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GROW:      cfg_reg.grow_factor   <= cfg_data[GROW_W-1:0];
                CFG_SHRINK:    cfg_reg.shrink_factor <= cfg_data[SHRINK_W-1:0];
                CFG_STEP_MAX:  cfg_reg.step_max      <= cfg_data[STEP_W-1:0];
                CFG_STEP_MIN:  cfg_reg.step_min      <= cfg_data[STEP_W-1:0];
                CFG_STEP_INIT: cfg_reg.step_init     <= cfg_data[STEP_W-1:0];
                CFG_DECAY:     cfg_reg.decay         <= cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

>>> design/irp_pipe.sv
// Read-modify-write pipeline: entry fetch, products, step rule, weight move, output register.
module irp_pipe (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  irp_pkg::cfg_t                    cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  irp_pkg::mode_t                   s_mode,
    input  logic [irp_pkg::IDX_W-1:0]        s_idx,
    input  logic [irp_pkg::WORD_W-1:0]       s_grad,
    input  logic [irp_pkg::WORD_W-1:0]       s_load,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [irp_pkg::IDX_W-1:0]        m_idx,
    output logic [irp_pkg::WORD_W-1:0]       m_weight,
    output logic [irp_pkg::STEP_W-1:0]       m_step,
    output irp_pkg::sgn_t                    m_sign,
    output logic                             rd_en,
    output logic [irp_pkg::ADDR_W-1:0]       rd_addr,
    input  irp_pkg::entry_t                  rd_data,
    output logic                             wr_en,
    output logic [irp_pkg::ADDR_W-1:0]       wr_addr,
    output irp_pkg::entry_t                  wr_data
);
    import irp_pkg::*;

    localparam int DW_W     = WORD_W + DECAY_W + 1;
    localparam int DW_SH_W  = DW_W - FRAC_BITS;
    localparam int G_W      = ((DW_SH_W > WORD_W) ? DW_SH_W : WORD_W) + 1;
    localparam int PLUS_W   = STEP_W + GROW_W;
    localparam int MINUS_W  = STEP_W + SHRINK_W;
    localparam int WSUM_W   = WORD_W + 1;

    logic                      advance;
    logic                      hazard;
    logic                      accept;
    logic [ADDR_W-1:0]         s_addr;

    logic                      v1_reg, v2_reg, v3_reg, out_valid_reg;

    mode_t                     p1_mode_reg;
    logic [ADDR_W-1:0]         p1_addr_reg;
    logic [WORD_W-1:0]         p1_grad_reg;
    logic [WORD_W-1:0]         p1_load_reg;

    mode_t                     p2_mode_reg;
    logic [ADDR_W-1:0]         p2_addr_reg;
    logic [WORD_W-1:0]         p2_grad_reg;
    logic [WORD_W-1:0]         p2_load_reg;
    entry_t                    p2_entry_reg;
    logic signed [DW_W-1:0]    prod_dw_reg, prod_dw_next;
    logic [PLUS_W-1:0]         prod_plus_reg, prod_plus_next;
    logic [MINUS_W-1:0]        prod_minus_reg, prod_minus_next;

    mode_t                     p3_mode_reg;
    logic [ADDR_W-1:0]         p3_addr_reg;
    logic [WORD_W-1:0]         p3_weight_reg, p3_weight_next;
    logic [STEP_W-1:0]         p3_step_reg, p3_step_next;
    sgn_t                      p3_sign_reg, p3_sign_next;

    logic [ADDR_W-1:0]         out_addr_reg;
    logic [WORD_W-1:0]         out_weight_reg, out_weight_next;
    logic [STEP_W-1:0]         out_step_reg;
    sgn_t                      out_sign_reg;

    logic signed [DW_SH_W-1:0] dw_sh;
    logic signed [G_W-1:0]     g_eff;
    sgn_t                      cur_sign;
    logic [PLUS_W-1:0]         grown;
    logic [MINUS_W-1:0]        shrunk;
    logic [STEP_W-1:0]         step_grown;
    logic [STEP_W-1:0]         step_shrunk;
    logic signed [WSUM_W-1:0]  w_ext;
    logic signed [WSUM_W-1:0]  stp_ext;
    logic signed [WSUM_W-1:0]  wsum;

    assign advance = !out_valid_reg || m_ready;
    assign s_addr  = s_idx[ADDR_W-1:0];

    // Hold off any item whose entry is still being rewritten further down.
    assign hazard = (v1_reg && is_writer(p1_mode_reg) && (p1_addr_reg == s_addr)) ||
                    (v2_reg && is_writer(p2_mode_reg) && (p2_addr_reg == s_addr)) ||
                    (v3_reg && is_writer(p3_mode_reg) && (p3_addr_reg == s_addr));

    assign s_ready = advance && !hazard;
    assign accept  = s_valid && s_ready;
    assign rd_en   = accept;
    assign rd_addr = s_addr;

    always_comb begin
        prod_dw_next    = DW_W'($signed({1'b0, cfg.decay})) * DW_W'($signed(rd_data.weight));
        prod_plus_next  = PLUS_W'(rd_data.step) * PLUS_W'(cfg.grow_factor);
        prod_minus_next = MINUS_W'(rd_data.step) * MINUS_W'(cfg.shrink_factor);
    end

    always_comb begin
        dw_sh  = DW_SH_W'(prod_dw_reg >>> FRAC_BITS);
        g_eff  = G_W'($signed(p2_grad_reg)) + G_W'(dw_sh);
        if (g_eff > 0) begin
            cur_sign = SGN_POS;
        end else if (g_eff < 0) begin
            cur_sign = SGN_NEG;
        end else begin
            cur_sign = SGN_ZERO;
        end

        grown = prod_plus_reg >> FRAC_BITS;
        if (grown > PLUS_W'(cfg.step_max)) begin
            step_grown = cfg.step_max;
        end else begin
            step_grown = grown[STEP_W-1:0];
        end

        shrunk = prod_minus_reg >> FRAC_BITS;
        if (shrunk < MINUS_W'(cfg.step_min)) begin
            step_shrunk = cfg.step_min;
        end else if (shrunk > MINUS_W'({STEP_W{1'b1}})) begin
            step_shrunk = {STEP_W{1'b1}};
        end else begin
            step_shrunk = shrunk[STEP_W-1:0];
        end

        p3_weight_next = p2_entry_reg.weight;
        p3_step_next   = p2_entry_reg.step;
        p3_sign_next   = p2_entry_reg.sign;
        case (p2_mode_reg)
            MODE_UPDATE: begin
                p3_sign_next = cur_sign;
                if ((p2_entry_reg.sign != SGN_ZERO) && (cur_sign != SGN_ZERO)) begin
                    if (p2_entry_reg.sign == cur_sign) begin
                        p3_step_next = step_grown;
                    end else begin
                        p3_step_next = step_shrunk;
                        p3_sign_next = SGN_ZERO;
                    end
                end
            end
            MODE_LOAD: begin
                p3_weight_next = p2_load_reg;
                p3_step_next   = cfg.step_init;
                p3_sign_next   = SGN_ZERO;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_ext   = WSUM_W'($signed(p3_weight_reg));
        stp_ext = $signed(WSUM_W'(p3_step_reg));
        wsum    = w_ext;
        if (p3_mode_reg == MODE_UPDATE) begin
            if (p3_sign_reg == SGN_NEG) begin
                wsum = w_ext + stp_ext;
            end else if (p3_sign_reg == SGN_POS) begin
                wsum = w_ext - stp_ext;
            end
        end
        if (wsum[WSUM_W-1] != wsum[WSUM_W-2]) begin
            out_weight_next = wsum[WSUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                             : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            out_weight_next = wsum[WORD_W-1:0];
        end
    end

    assign wr_en          = v3_reg && advance && is_writer(p3_mode_reg);
    assign wr_addr        = p3_addr_reg;
    assign wr_data.sign   = p3_sign_reg;
    assign wr_data.step   = p3_step_reg;
    assign wr_data.weight = out_weight_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_mode_reg    <= s_mode;
            p1_addr_reg    <= s_addr;
            p1_grad_reg    <= s_grad;
            p1_load_reg    <= s_load;

            p2_mode_reg    <= p1_mode_reg;
            p2_addr_reg    <= p1_addr_reg;
            p2_grad_reg    <= p1_grad_reg;
            p2_load_reg    <= p1_load_reg;
            p2_entry_reg   <= rd_data;
            prod_dw_reg    <= prod_dw_next;
            prod_plus_reg  <= prod_plus_next;
            prod_minus_reg <= prod_minus_next;

            p3_mode_reg    <= p2_mode_reg;
            p3_addr_reg    <= p2_addr_reg;
            p3_weight_reg  <= p3_weight_next;
            p3_step_reg    <= p3_step_next;
            p3_sign_reg    <= p3_sign_next;

            out_addr_reg   <= p3_addr_reg;
            out_weight_reg <= out_weight_next;
            out_step_reg   <= p3_step_reg;
            out_sign_reg   <= p3_sign_reg;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_idx    = IDX_W'(out_addr_reg);
    assign m_weight = out_weight_reg;
    assign m_step   = out_step_reg;
    assign m_sign   = out_sign_reg;

    a_no_dup_12: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && is_writer(p1_mode_reg) && is_writer(p2_mode_reg))
        |-> (p1_addr_reg != p2_addr_reg))
        else $error("two writers to one entry in stages 1 and 2");

    a_no_dup_13: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v3_reg && is_writer(p1_mode_reg) && is_writer(p3_mode_reg))
        |-> (p1_addr_reg != p3_addr_reg))
        else $error("two writers to one entry in stages 1 and 3");

    a_no_dup_23: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && v3_reg && is_writer(p2_mode_reg) && is_writer(p3_mode_reg))
        |-> (p2_addr_reg != p3_addr_reg))
        else $error("two writers to one entry in stages 2 and 3");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted beat lost before the first stage");

endmodule

>>> design/irprop_minus_weight_update.sv
// Top level of the iRPROP- weight update engine.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata with the mode in s_tuser:
// update applies a gradient to one stored weight, load writes a weight and
// resets its step to step_init and its sign to zero, read reports an entry.
// Every beat yields exactly one result beat on m_tvalid/m_tready/m_tdata,
// in order. Registers are written through cfg_valid/cfg_index/cfg_data, always
// ready; the user must write them only while no beat is in flight, as the block
// does not enforce it. Each beat is registered in the p1, p2, p3 and output stages.
// Throughput: one beat per cycle unless s_tready is held low. A beat of any
// mode whose entry one of the three stages ahead is still rewriting holds
// s_tready low until that write-back lands; the index compare against those
// stages before the entry RAM read sets this.
// Reset clears the pipeline valids and loads the register defaults; the
// weight store is undefined until each entry is loaded.
// When m_tready is low and the output register is full, the whole pipeline
// holds and s_tready drops.
module irprop_minus_weight_update (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight_index[11:0], gradient[43:12], load_value[75:44], zero pad
    input  logic [irp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode[1:0]
    input  logic [irp_pkg::MODE_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // index_out[11:0], weight_out[43:12], step_out[74:44], sign_out[76:75], zero pad
    output logic [irp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import irp_pkg::*;

    cfg_t               cfg;
    logic [IDX_W-1:0]   s_idx;
    logic [WORD_W-1:0]  s_grad;
    logic [WORD_W-1:0]  s_load;
    logic [IDX_W-1:0]   m_idx;
    logic [WORD_W-1:0]  m_weight;
    logic [STEP_W-1:0]  m_step;
    sgn_t               m_sign;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    entry_t             rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    assign s_idx  = s_tdata[IDX_W-1:0];
    assign s_grad = s_tdata[IDX_W+WORD_W-1:IDX_W];
    assign s_load = s_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];

    assign m_tdata = OUT_TDATA_W'({m_sign, m_step, m_weight, m_idx});

    irp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    irp_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_mode   (s_tuser),
        .s_idx    (s_idx),
        .s_grad   (s_grad),
        .s_load   (s_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_idx    (m_idx),
        .m_weight (m_weight),
        .m_step   (m_step),
        .m_sign   (m_sign),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    irp_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (NUM_WEIGHTS)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
